### sv/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants for the tilt complementary filter
// Fixed-point constants, arctangent table and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;   // legal range 8..24
    localparam int CNT_W            = 5;    // holds any step index below 24
    localparam int SQRT_STEPS       = 24;   // root bits of a 48-bit radicand

    localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [16:0] WEIGHT_RESET = 17'd64225;

    localparam logic signed [24:0] ANGLE_LIMIT = 25'sd11796480;
    localparam logic signed [24:0] RIGHT_ANGLE = 25'sd5898240;

    // degrees*65536 per radian*2^30, numerator of 65536*180/3.14 scaled by 100
    localparam logic [32:0] CONV_MUL = 33'd1179648000;
    // reciprocals: floor(u/314) = (u*M314)>>40, u < 2^31
    localparam logic [31:0] M314     = 32'd3501629388;
    // floor(u/131) = (u*M131)>>24, u <= 32768
    localparam logic [32:0] M131     = 33'd128071;
    // floor(u/125) = (u*M125)>>38, u < 2^31
    localparam logic [31:0] M125     = 32'd2199023256;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ROOT,
        S_ROOT_WAIT,
        S_CORDIC_WAIT,
        S_CONV_Z,
        S_CONV_U,
        S_CONV_Q,
        S_GYRO_Q,
        S_GYRO_P,
        S_GYRO_S,
        S_BLEND_A,
        S_BLEND_B,
        S_BLEND_C,
        S_EMIT
    } state_t;

    // atan(2^-i) in radians Q30
    function automatic logic signed [31:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd843314857;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043837;
            5'd3:    v = 32'sd133525159;
            5'd4:    v = 32'sd67021687;
            5'd5:    v = 32'sd33543516;
            5'd6:    v = 32'sd16775851;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194283;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048576;
            5'd11:   v = 32'sd524288;
            5'd12:   v = 32'sd262144;
            5'd13:   v = 32'sd131072;
            5'd14:   v = 32'sd65536;
            5'd15:   v = 32'sd32768;
            5'd16:   v = 32'sd16384;
            5'd17:   v = 32'sd8192;
            5'd18:   v = 32'sd4096;
            5'd19:   v = 32'sd2048;
            5'd20:   v = 32'sd1024;
            5'd21:   v = 32'sd512;
            5'd22:   v = 32'sd256;
            5'd23:   v = 32'sd128;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/tcf_mul.sv
// ----------------------------------------------------------------------------
// tcf_mul: shared registered multiplier
// Signed 33x33 product, registered; result is valid the cycle after issue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_mul (
    input  wire logic               clk,
    input  wire logic signed [32:0] op_a,
    input  wire logic signed [32:0] op_b,
    output logic signed [65:0]      prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

endmodule

`default_nettype wire

### sv/tcf_sqrt.sv
// ----------------------------------------------------------------------------
// tcf_sqrt: iterative integer square root
// Digit-by-digit floor root of a 48-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] rad_in,
    output logic             done,
    output logic [23:0]      root
);

    localparam logic [tcf_pkg::CNT_W-1:0] LAST = tcf_pkg::CNT_W'(tcf_pkg::SQRT_STEPS - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [tcf_pkg::CNT_W-1:0] cnt_reg;
    logic [47:0]               rad_reg;
    logic [26:0]               rem_reg;
    logic [23:0]               root_reg;

    logic [26:0] rem_shift;
    logic [26:0] trial;
    logic        fits;

    assign rem_shift = {rem_reg[24:0], rad_reg[47:46]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[45:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[22:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### sv/tcf_cordic.sv
// ----------------------------------------------------------------------------
// tcf_cordic: iterative CORDIC vectoring unit
// Drives y toward zero, one micro-rotation per cycle; angle in radians Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_cordic #(
    parameter int STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [23:0]        x_in,
    input  wire logic signed [24:0] y_in,
    output logic                    done,
    output logic signed [31:0]      z_out
);

    localparam logic [tcf_pkg::CNT_W-1:0] LAST = tcf_pkg::CNT_W'(STEPS - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [tcf_pkg::CNT_W-1:0] cnt_reg;
    logic signed [27:0]        x_reg;
    logic signed [27:0]        y_reg;
    logic signed [31:0]        z_reg;

    logic signed [27:0] dx;
    logic signed [27:0] dy;
    logic signed [31:0] t;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign t  = tcf_pkg::atan_q30(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= {4'b0000, x_in};
            y_reg <= {{3{y_in[24]}}, y_in};
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[27])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + t;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - t;
            end
        end
    end

    assign done  = done_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

### sv/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter: IMU tilt angles by complementary filtering
// Sequencer over a shared multiplier, root unit and CORDIC unit, axis by axis.
// ----------------------------------------------------------------------------
// An axis with zero numerator or denominator skips root and CORDIC. A new
//   sample is accepted only in idle, after the previous result has been
//   loaded for output; root and CORDIC run per axis.
// Reset: asynchronous; clears angle state to zero, weight to 64225, no result held.
`default_nettype none

module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               weight_we,
    input  wire logic [16:0]        weight_data,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic [9:0]         elapsed_ms,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [24:0]      angle_x,
    output logic signed [24:0]      angle_y
);

    tcf_pkg::state_t state_reg;
    tcf_pkg::state_t state_next;

    logic [16:0]        weight_reg;
    logic               axis_reg;
    logic               sign_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [9:0]         ms_reg;
    logic [31:0]        d2_reg;
    logic signed [24:0] acc_reg;
    logic signed [45:0] part_reg;
    logic signed [24:0] prev_x_reg, prev_y_reg;
    logic               result_valid_reg;
    logic signed [24:0] angle_x_reg, angle_y_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_reg;
    logic               sqrt_start, sqrt_done;
    logic [23:0]        root;
    logic               cordic_start, cordic_done;
    logic signed [31:0] cz;

    logic               in_xfer, out_xfer, emit_load;

    logic signed [16:0] num_sel;
    logic signed [15:0] a_sel, g_sel;
    logic signed [24:0] prev_sel;
    logic [31:0]        d2_sum;
    logic               num_zero, d2_zero;
    logic [65:0]        conv_mag;
    logic [30:0]        conv_u;
    logic [22:0]        conv_q;
    logic signed [24:0] conv_acc;
    logic [16:0]        g_mag;
    logic [7:0]         rq;
    logic signed [8:0]  rq_s;
    logic [18:0]        p_mag;
    logic [24:0]        step_mag;
    logic signed [25:0] step;
    logic signed [26:0] blend_sum;
    logic signed [45:0] blend_v, blend_t;
    logic signed [29:0] blend_q;
    logic signed [24:0] blend_sat;
    logic [16:0]        acc_weight;

    assign in_xfer   = sample_valid && !sample_stall;
    assign out_xfer  = result_valid_reg && !result_stall;
    assign emit_load = (state_reg == tcf_pkg::S_EMIT) && (!result_valid_reg || !result_stall);

    // per-axis operand selection
    assign num_sel  = axis_reg ? -{ax_reg[15], ax_reg} : {ay_reg[15], ay_reg};
    assign a_sel    = axis_reg ? ay_reg : ax_reg;
    assign g_sel    = axis_reg ? gy_reg : gx_reg;
    assign prev_sel = axis_reg ? prev_y_reg : prev_x_reg;

    assign d2_sum   = d2_reg + prod_reg[31:0];
    assign num_zero = (num_sel == 17'sd0);
    assign d2_zero  = (d2_sum == 32'd0);

    // degrees = trunc(z*C / (314*2^30)), done on the magnitude
    assign conv_mag = prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
    assign conv_u   = conv_mag[60:30];
    assign conv_q   = prod_reg[62:40];
    assign conv_acc = sign_reg ? -{2'b00, conv_q} : {2'b00, conv_q};

    assign g_mag    = g_sel[15] ? -{g_sel[15], g_sel} : {g_sel[15], g_sel};
    assign rq       = prod_reg[31:24];
    assign rq_s     = sign_reg ? -{1'b0, rq} : {1'b0, rq};
    assign p_mag    = prod_reg[65] ? -prod_reg[18:0] : prod_reg[18:0];
    assign step_mag = prod_reg[62:38];
    assign step     = sign_reg ? -{1'b0, step_mag} : {1'b0, step_mag};

    assign blend_sum  = {{2{prev_sel[24]}}, prev_sel} + {step[25], step};
    assign acc_weight = tcf_pkg::WEIGHT_ONE - weight_reg;
    assign blend_v    = part_reg + prod_reg[45:0];
    assign blend_t    = blend_v + (blend_v[45] ? 46'sd65535 : 46'sd0);
    assign blend_q    = blend_t[45:16];

    always_comb
    begin
        if (blend_q > 30'(tcf_pkg::ANGLE_LIMIT))
            blend_sat = tcf_pkg::ANGLE_LIMIT;
        else if (blend_q < -30'(tcf_pkg::ANGLE_LIMIT))
            blend_sat = -tcf_pkg::ANGLE_LIMIT;
        else
            blend_sat = blend_q[24:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcf_pkg::S_IDLE:        if (in_xfer) state_next = tcf_pkg::S_MUL_A;
            tcf_pkg::S_MUL_A:       state_next = tcf_pkg::S_MUL_B;
            tcf_pkg::S_MUL_B:       state_next = tcf_pkg::S_ROOT;
            tcf_pkg::S_ROOT:
            begin
                if (num_zero || d2_zero)
                    state_next = tcf_pkg::S_GYRO_Q;
                else
                    state_next = tcf_pkg::S_ROOT_WAIT;
            end
            tcf_pkg::S_ROOT_WAIT:   if (sqrt_done) state_next = tcf_pkg::S_CORDIC_WAIT;
            tcf_pkg::S_CORDIC_WAIT: if (cordic_done) state_next = tcf_pkg::S_CONV_Z;
            tcf_pkg::S_CONV_Z:      state_next = tcf_pkg::S_CONV_U;
            tcf_pkg::S_CONV_U:      state_next = tcf_pkg::S_CONV_Q;
            tcf_pkg::S_CONV_Q:      state_next = tcf_pkg::S_GYRO_Q;
            tcf_pkg::S_GYRO_Q:      state_next = tcf_pkg::S_GYRO_P;
            tcf_pkg::S_GYRO_P:      state_next = tcf_pkg::S_GYRO_S;
            tcf_pkg::S_GYRO_S:      state_next = tcf_pkg::S_BLEND_A;
            tcf_pkg::S_BLEND_A:     state_next = tcf_pkg::S_BLEND_B;
            tcf_pkg::S_BLEND_B:     state_next = tcf_pkg::S_BLEND_C;
            tcf_pkg::S_BLEND_C:
            begin
                if (axis_reg)
                    state_next = tcf_pkg::S_EMIT;
                else
                    state_next = tcf_pkg::S_MUL_A;
            end
            tcf_pkg::S_EMIT:        if (emit_load) state_next = tcf_pkg::S_IDLE;
            default:                state_next = tcf_pkg::S_IDLE;
        endcase
    end

    // unit controls and multiplier operands
    always_comb
    begin
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        op_a         = '0;
        op_b         = '0;
        case (state_reg)
            tcf_pkg::S_MUL_A:
            begin
                op_a = {{17{a_sel[15]}}, a_sel};
                op_b = {{17{a_sel[15]}}, a_sel};
            end
            tcf_pkg::S_MUL_B:
            begin
                op_a = {{17{az_reg[15]}}, az_reg};
                op_b = {{17{az_reg[15]}}, az_reg};
            end
            tcf_pkg::S_ROOT:
            begin
                sqrt_start = !num_zero && !d2_zero;
            end
            tcf_pkg::S_ROOT_WAIT:
            begin
                cordic_start = sqrt_done;
            end
            tcf_pkg::S_CONV_Z:
            begin
                op_a = {cz[31], cz};
                op_b = tcf_pkg::CONV_MUL;
            end
            tcf_pkg::S_CONV_U:
            begin
                op_a = {2'b00, conv_u};
                op_b = {1'b0, tcf_pkg::M314};
            end
            tcf_pkg::S_GYRO_Q:
            begin
                op_a = {16'd0, g_mag};
                op_b = tcf_pkg::M131;
            end
            tcf_pkg::S_GYRO_P:
            begin
                op_a = {{24{rq_s[8]}}, rq_s};
                op_b = {23'd0, ms_reg};
            end
            tcf_pkg::S_GYRO_S:
            begin
                op_a = {1'b0, p_mag, 13'd0};
                op_b = {1'b0, tcf_pkg::M125};
            end
            tcf_pkg::S_BLEND_A:
            begin
                op_a = {16'd0, weight_reg};
                op_b = {{6{blend_sum[26]}}, blend_sum};
            end
            tcf_pkg::S_BLEND_B:
            begin
                op_a = {16'd0, acc_weight};
                op_b = {{8{acc_reg[24]}}, acc_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcf_pkg::S_IDLE;
            weight_reg       <= tcf_pkg::WEIGHT_RESET;
            axis_reg         <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (weight_we)
                weight_reg <= (weight_data > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE
                                                                  : weight_data;
            if (in_xfer)
                axis_reg <= 1'b0;
            else if (state_reg == tcf_pkg::S_BLEND_C)
                axis_reg <= ~axis_reg;
            if (state_reg == tcf_pkg::S_BLEND_C)
            begin
                if (axis_reg)
                    prev_y_reg <= blend_sat;
                else
                    prev_x_reg <= blend_sat;
            end
            if (emit_load)
                result_valid_reg <= 1'b1;
            else if (out_xfer)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            ms_reg <= (elapsed_ms > 10'd1000) ? 10'd1000 : elapsed_ms;
        end
        case (state_reg)
            tcf_pkg::S_MUL_B:
            begin
                d2_reg <= prod_reg[31:0];
            end
            tcf_pkg::S_ROOT:
            begin
                if (num_zero)
                    acc_reg <= '0;
                else if (d2_zero)
                    acc_reg <= num_sel[16] ? -tcf_pkg::RIGHT_ANGLE : tcf_pkg::RIGHT_ANGLE;
            end
            tcf_pkg::S_CONV_U:  sign_reg <= prod_reg[65];
            tcf_pkg::S_CONV_Q:  acc_reg  <= conv_acc;
            tcf_pkg::S_GYRO_Q:  sign_reg <= g_sel[15];
            tcf_pkg::S_GYRO_S:  sign_reg <= prod_reg[65];
            tcf_pkg::S_BLEND_B: part_reg <= prod_reg[45:0];
            default:
            begin
            end
        endcase
        if (emit_load)
        begin
            angle_x_reg <= prev_x_reg;
            angle_y_reg <= prev_y_reg;
        end
    end

    tcf_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    tcf_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqrt_start),
        .rad_in ({d2_sum, 16'd0}),
        .done   (sqrt_done),
        .root   (root)
    );

    tcf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (root),
        .y_in  ({num_sel, 8'd0}),
        .done  (cordic_done),
        .z_out (cz)
    );

    assign sample_stall = (state_reg != tcf_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign angle_x      = angle_x_reg;
    assign angle_y      = angle_y_reg;

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (angle_x <= tcf_pkg::ANGLE_LIMIT) && (angle_x >= -tcf_pkg::ANGLE_LIMIT)
                      && (angle_y <= tcf_pkg::ANGLE_LIMIT) && (angle_y >= -tcf_pkg::ANGLE_LIMIT))
        else $error("angle out of range");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == tcf_pkg::S_MUL_A) && !axis_reg)
        else $error("sample transfer did not start axis x");

    a_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == tcf_pkg::S_ROOT_WAIT))
        else $error("root done outside wait");

    a_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == tcf_pkg::S_CORDIC_WAIT))
        else $error("cordic done outside wait");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the tilt complementary filter
// Directed table then random IMU samples; results checked against a predictor
// with its own angle state and blend weight, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEPS      = tcf_pkg::CORDIC_STEPS_DEF;
    localparam int  WDOG_LIMIT = 20000;
    localparam int  N_RANDOM   = 1830;
    localparam longint RANGLE  = 5898240;
    localparam longint ALIMIT  = 11796480;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy;
        logic [9:0]         ms;
        logic               chk;   // typed-in expectation present
        logic signed [24:0] ex, ey;
    } sample_t;

    typedef struct {
        logic signed [24:0] x, y;
    } angles_t;

    logic clk;
    logic rst_n;
    logic weight_we;
    logic [16:0] weight_data;
    logic sample_valid;
    logic sample_stall;
    logic signed [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y;
    logic [9:0] elapsed_ms;
    logic result_valid;
    logic result_stall;
    logic signed [24:0] angle_x, angle_y;

    tilt_complementary_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .weight_we(weight_we), .weight_data(weight_data),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y), .elapsed_ms(elapsed_ms),
        .result_valid(result_valid), .result_stall(result_stall),
        .angle_x(angle_x), .angle_y(angle_y)
    );

    // predictor state
    longint  gyro_weight;
    longint  tilt_x_q, tilt_y_q;
    angles_t angles_due[$];
    int      mismatches;
    int      watchdog;
    bit      timed_out;

    localparam longint ATAN_TBL [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint accel_tilt(longint num, longint a, longint b);
        longint d2, x, y, z, dx, dy;
        z = 0;
        d2 = a * a + b * b;
        if (num == 0) return 0;
        if (d2 == 0) return (num > 0) ? RANGLE : -RANGLE;
        x = int_root(d2 <<< 16);
        y = num * 256;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        return (z * 64'sd1179648000) / (64'sd314 <<< 30);
    endfunction

    function automatic longint blend_axis(longint prev, longint rate, longint ms,
                                          longint acc);
        longint q, stp, v;
        q = rate / 131;
        stp = (q * ms * 65536) / 1000;
        v = (gyro_weight * (prev + stp) + (65536 - gyro_weight) * acc) / 65536;
        if (v > ALIMIT) v = ALIMIT;
        if (v < -ALIMIT) v = -ALIMIT;
        return v;
    endfunction

    function automatic angles_t predict_angles(sample_t s);
        longint ms;
        angles_t r;
        ms = (s.ms > 1000) ? 1000 : s.ms;
        tilt_x_q = blend_axis(tilt_x_q, s.gx, ms, accel_tilt(s.ay, s.ax, s.az));
        tilt_y_q = blend_axis(tilt_y_q, s.gy, ms, accel_tilt(-longint'(s.ax), s.ay, s.az));
        r.x = tilt_x_q[24:0];
        r.y = tilt_y_q[24:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
    end

    always @(posedge clk)
    begin
        if (watchdog >= WDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", angle_x, angle_y);
            end
            else
            begin
                e = angles_due.pop_front();
                if (angle_x !== e.x || angle_y !== e.y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                                 e.x, e.y, angle_x, angle_y);
                end
            end
        end
    end

    // receiver idling: stall for a random count before each transfer
    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(0, 19);
            if (n != 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // valid stays high after the transfer only when the next sample follows at once
    task automatic send_sample(sample_t s, int gap);
        angles_t p;
        @(negedge clk);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
        gyro_x <= s.gx; gyro_y <= s.gy; elapsed_ms <= s.ms;
        sample_valid <= 1'b1;
        do @(posedge clk); while (sample_stall);
        p = predict_angles(s);
        if (s.chk && (p.x !== s.ex || p.y !== s.ey))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: exp x=%0d y=%0d pred x=%0d y=%0d",
                         s.ex, s.ey, p.x, p.y);
        end
        angles_due.push_back(p);
    endtask

    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_weight(logic [16:0] w);
        @(negedge clk);
        weight_we <= 1'b1;
        weight_data <= w;
        @(negedge clk);
        weight_we <= 1'b0;
        gyro_weight = (w > 65536) ? 65536 : w;
    endtask

    function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int ms,
                                   bit chk = 0, int ex = 0, int ey = 0);
        sample_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy); s.ms = 10'(ms);
        s.chk = chk; s.ex = 25'(ex); s.ey = 25'(ey);
        return s;
    endfunction

    function automatic logic signed [15:0] rand_accel();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        sample_t dir_table[$];
        sample_t s;
        logic [16:0] wsets [6];
        int k;
        rst_n = 1'b0;
        weight_we = 1'b0; weight_data = '0;
        sample_valid = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        gyro_x = '0; gyro_y = '0; elapsed_ms = '0;
        mismatches = 0; watchdog = 0; timed_out = 0;
        gyro_weight = 64225; tilt_x_q = 0; tilt_y_q = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // weight at reset, all-zero sample gives zero angles
        dir_table.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0));
        // zero denominator, zero numerator and right-angle cases
        dir_table.push_back(mk(0, 100, 0, 0, 0, 10));
        dir_table.push_back(mk(0, -100, 0, 0, 0, 10));
        dir_table.push_back(mk(100, 0, 0, 0, 0, 10));
        dir_table.push_back(mk(-100, 0, 0, 0, 0, 10));
        dir_table.push_back(mk(0, 0, 16384, 0, 0, 10));
        // field extremes
        dir_table.push_back(mk(-32768, -32768, -32768, -32768, -32768, 1000));
        dir_table.push_back(mk(32767, 32767, 32767, 32767, 32767, 1000));
        dir_table.push_back(mk(-32768, 32767, 0, 32767, -32768, 1023));
        dir_table.push_back(mk(32767, -32768, -32768, -32768, 32767, 1023));
        dir_table.push_back(mk(1, -1, 1, 130, -130, 1));
        dir_table.push_back(mk(-1, 1, -1, 131, -131, 999));
        dir_table.push_back(mk(0, 0, 0, 32767, 32767, 1000));
        dir_table.push_back(mk(0, 0, 0, 32767, 32767, 1000));
        dir_table.push_back(mk(0, 0, 0, -32768, -32768, 1000));
        foreach (dir_table[i])
            send_sample(dir_table[i], $urandom_range(0, 19));
        drain_results();

        // weight extremes, including above one
        write_weight(17'd0);
        send_sample(mk(0, 100, 0, 500, 500, 100), 0);
        send_sample(mk(0, -100, 0, 0, 0, 0), 3);
        drain_results();
        write_weight(17'h1ffff);
        send_sample(mk(1000, 0, 0, 5000, -5000, 500), 0);
        drain_results();

        wsets = '{17'd0, 17'd65536, 17'd64225, 17'd32768, 17'd131071, 17'd1};
        k = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 300 == 0)
            begin
                // sender holds off until the block is empty, then reweights
                drain_results();
                write_weight((k < 6) ? wsets[k] : 17'($urandom));
                k++;
            end
            s = mk(rand_accel(), rand_accel(), rand_accel(), $urandom, $urandom,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1001, 1023)
                                               : $urandom_range(0, 1000));
            if ($urandom_range(0, 7) == 0) s.ms = 0;
            send_sample(s, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        end
        drain_results();
        if (mismatches == 0 && angles_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/tcf_pkg.sv
sv/tcf_mul.sv
sv/tcf_sqrt.sv
sv/tcf_cordic.sv
sv/tilt_complementary_filter.sv
sim/tb.sv
